// ===== rtl/ppq_pkg.sv =====
package ppq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_REM_HEAD = 2'd1,
        OP_REM_PID  = 2'd2,
        OP_STATUS   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_EMPTY     = 2'd2,
        STS_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WAVE = 1'b1
    } t_state;

    localparam int PID_W   = 31;
    localparam int PRI_W   = 8;
    localparam int COUNT_W = 7;

    // byte address of the priority_mode register
    localparam logic [1:0] REG_PMODE = 2'd0;

    typedef struct packed {
        logic [1:0]       mode;
        logic [PID_W-1:0] in_pid;
        logic [PRI_W-1:0] in_priority;
    } t_cmd;

    typedef struct packed {
        logic [PID_W-1:0]   out_pid;
        logic [PRI_W-1:0]   out_priority;
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
    } t_res;

    // token that walks down the row of cells, one cell per cycle
    typedef struct packed {
        logic             act;
        logic             hit;
        logic [PID_W-1:0] pid;
        logic [PRI_W-1:0] pri;
    } t_tok;

    // op held steady while a token walks the row; pmode is not
    typedef struct packed {
        t_op  op;
        logic pmode;
    } t_bcast;

endpackage

// ===== rtl/ppq_cell.sv =====
module ppq_cell #(
    parameter int DEPTH = 64,
    parameter int IDX   = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ppq_pkg::t_bcast               i_bc,
    input  logic [$clog2(DEPTH+1)-1:0]    i_cnt,
    input  ppq_pkg::t_tok                 i_tok,
    input  logic [ppq_pkg::PID_W-1:0]     i_nxt_pid,
    input  logic [ppq_pkg::PRI_W-1:0]     i_nxt_pri,
    output ppq_pkg::t_tok                 o_tok,
    output logic [ppq_pkg::PID_W-1:0]     o_pid,
    output logic [ppq_pkg::PRI_W-1:0]     o_pri
);

    localparam int              CW    = $clog2(DEPTH+1);
    localparam logic [CW-1:0]   IDX_C = CW'(IDX);

    logic [ppq_pkg::PID_W-1:0] r_pid, n_pid;
    logic [ppq_pkg::PRI_W-1:0] r_pri, n_pri;
    ppq_pkg::t_tok             r_tok, n_tok;
    logic                      w_valid;
    logic                      w_tail;
    logic                      w_match;

    assign w_valid = IDX_C < i_cnt;
    assign w_tail  = IDX_C == i_cnt;

    always_comb begin
        if (i_bc.op == ppq_pkg::OP_REM_HEAD) begin
            w_match = IDX_C == '0;
        end else begin
            w_match = r_pid == i_tok.pid;
        end
    end

    always_comb begin
        n_pid = r_pid;
        n_pri = r_pri;
        n_tok = i_tok;
        if (i_tok.act) begin
            case (i_bc.op)
                ppq_pkg::OP_INSERT: begin
                    if (w_valid) begin
                        // from the insertion point on, every entry moves one place back
                        if (i_tok.hit || (i_bc.pmode && (r_pri < i_tok.pri))) begin
                            n_pid     = i_tok.pid;
                            n_pri     = i_tok.pri;
                            n_tok.pid = r_pid;
                            n_tok.pri = r_pri;
                            n_tok.hit = 1'b1;
                        end
                    end else if (w_tail) begin
                        n_pid     = i_tok.pid;
                        n_pri     = i_tok.pri;
                        n_tok.hit = 1'b1;
                    end
                end
                ppq_pkg::OP_REM_HEAD, ppq_pkg::OP_REM_PID: begin
                    if (w_valid) begin
                        if (i_tok.hit) begin
                            n_pid = i_nxt_pid;
                            n_pri = i_nxt_pri;
                        end else if (w_match) begin
                            // the token now carries the removed entry
                            n_tok.hit = 1'b1;
                            n_tok.pid = r_pid;
                            n_tok.pri = r_pri;
                            n_pid     = i_nxt_pid;
                            n_pri     = i_nxt_pri;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_pid <= n_pid;
        r_pri <= n_pri;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.act <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;
    assign o_pid = r_pid;
    assign o_pri = r_pri;

endmodule

// ===== rtl/process_priority_queue.sv =====
// Process queue of up to DEPTH entries held in a row of cells, head in cell 0.
// An insert or a removal walks a token down the whole row, one cell a cycle,
// so its result strobes on o_done once the token has passed the last cell; busy
// is high meanwhile. A status query, a full insert or a removal from an empty
// queue answers on the cycle after start. busy is low again during the strobe
// cycle, so the next start may be taken then. Results are shown for exactly
// one cycle and cannot be held off by the receiver.
module process_priority_queue #(
    parameter int DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ppq_pkg::t_cmd       i_cmd,
    output logic                o_done,
    output ppq_pkg::t_res       o_res,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int            CW      = $clog2(DEPTH+1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    ppq_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_pmode, n_pmode;
    ppq_pkg::t_op     r_op, n_op;
    ppq_pkg::t_tok    r_tok0, n_tok0;
    logic             r_done, n_done;
    ppq_pkg::t_res    r_res, n_res;

    ppq_pkg::t_tok                w_tok [DEPTH+1];
    logic [ppq_pkg::PID_W-1:0]    w_pid [DEPTH];
    logic [ppq_pkg::PRI_W-1:0]    w_pri [DEPTH];
    ppq_pkg::t_bcast              w_bc;
    logic                         w_accept;
    logic                         w_wr;
    logic [CW+ppq_pkg::COUNT_W-1:0] w_cnt_ext;

    assign w_bc.op    = r_op;
    assign w_bc.pmode = r_pmode;
    assign w_tok[0]   = r_tok0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g < DEPTH - 1) begin : g_mid
                ppq_cell #(.DEPTH(DEPTH), .IDX(g)) u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_bc      (w_bc),
                    .i_cnt     (r_cnt),
                    .i_tok     (w_tok[g]),
                    .i_nxt_pid (w_pid[g+1]),
                    .i_nxt_pri (w_pri[g+1]),
                    .o_tok     (w_tok[g+1]),
                    .o_pid     (w_pid[g]),
                    .o_pri     (w_pri[g])
                );
            end else begin : g_last
                // nothing behind the last cell; what it takes on removal is never read
                ppq_cell #(.DEPTH(DEPTH), .IDX(g)) u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_bc      (w_bc),
                    .i_cnt     (r_cnt),
                    .i_tok     (w_tok[g]),
                    .i_nxt_pid ('0),
                    .i_nxt_pri ('0),
                    .o_tok     (w_tok[g+1]),
                    .o_pid     (w_pid[g]),
                    .o_pri     (w_pri[g])
                );
            end
        end
    endgenerate

    assign busy     = r_state != ppq_pkg::S_IDLE;
    assign w_accept = start && !busy;
    assign w_wr     = psel && penable && pwrite && (paddr == ppq_pkg::REG_PMODE);
    assign pready   = 1'b1;
    assign prdata   = (paddr == ppq_pkg::REG_PMODE) ? {31'd0, r_pmode} : 32'd0;

    assign w_cnt_ext = {{ppq_pkg::COUNT_W{1'b0}}, n_cnt};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_pmode = w_wr ? pwdata[0] : r_pmode;
        n_op    = r_op;
        n_tok0  = r_tok0;
        n_tok0.act = 1'b0;
        n_done  = 1'b0;
        n_res   = r_res;
        n_res.out_pid      = '0;
        n_res.out_priority = '0;
        n_res.status       = ppq_pkg::STS_OK;
        unique case (r_state)
            ppq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_done = 1'b1;
                    case (i_cmd.mode)
                        ppq_pkg::OP_INSERT: begin
                            if (r_cnt == DEPTH_C) begin
                                n_res.status = ppq_pkg::STS_FULL;
                            end else begin
                                n_done = 1'b0;
                            end
                        end
                        ppq_pkg::OP_REM_HEAD, ppq_pkg::OP_REM_PID: begin
                            if (r_cnt == '0) begin
                                n_res.status = ppq_pkg::STS_EMPTY;
                            end else begin
                                n_done = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (!n_done) begin
                        n_state    = ppq_pkg::S_WAVE;
                        n_op       = ppq_pkg::t_op'(i_cmd.mode);
                        n_tok0.act = 1'b1;
                        n_tok0.hit = 1'b0;
                        n_tok0.pid = i_cmd.in_pid;
                        n_tok0.pri = i_cmd.in_priority;
                    end
                end
            end
            ppq_pkg::S_WAVE: begin
                if (w_tok[DEPTH].act) begin
                    n_state = ppq_pkg::S_IDLE;
                    n_done  = 1'b1;
                    if (r_op == ppq_pkg::OP_INSERT) begin
                        n_cnt = r_cnt + 1'b1;
                    end else if (w_tok[DEPTH].hit) begin
                        n_cnt              = r_cnt - 1'b1;
                        n_res.out_pid      = w_tok[DEPTH].pid;
                        n_res.out_priority = w_tok[DEPTH].pri;
                    end else begin
                        n_res.status = ppq_pkg::STS_NOT_FOUND;
                    end
                end
            end
            default: begin
                n_state = ppq_pkg::S_IDLE;
            end
        endcase
        n_res.count    = w_cnt_ext[ppq_pkg::COUNT_W-1:0];
        n_res.is_empty = n_cnt == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ppq_pkg::S_IDLE;
            r_cnt      <= '0;
            r_pmode    <= 1'b0;
            r_done     <= 1'b0;
            r_tok0.act <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pmode <= n_pmode;
            r_done  <= n_done;
            r_tok0  <= n_tok0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/ppq_chk.sv =====
module ppq_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input ppq_pkg::t_cmd i_cmd,
    input logic          o_done,
    input ppq_pkg::t_res o_res
);

    // a result beat always leaves the block ready for the next command
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    a_status_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.mode == ppq_pkg::OP_STATUS))
        |=> (o_done && (o_res.status == ppq_pkg::STS_OK)))
        else $error("status query not answered on the next cycle");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("command taken but neither busy nor answered");

    a_count_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_res.count != '0)) |-> !o_res.is_empty)
        else $error("empty flag set with entries held");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_res.status != ppq_pkg::STS_OK))
        |-> ((o_res.out_pid == '0) && (o_res.out_priority == '0)))
        else $error("rejected beat carries an entry");

endmodule

bind process_priority_queue ppq_chk u_ppq_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_cmd   (i_cmd),
    .o_done  (o_done),
    .o_res   (o_res)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH = 64;
    localparam int N_ITEMS = 850;

    typedef struct {
        logic [ppq_pkg::PID_W-1:0] pid;
        logic [ppq_pkg::PRI_W-1:0] pri;
    } t_slot;

    typedef enum {
        ROW_CMD,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind     kind;
        ppq_pkg::t_cmd cmd;
        bit            cfg_val;
        bit            has_want;
        ppq_pkg::t_res want;
    } t_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    ppq_pkg::t_cmd i_cmd;
    logic          o_done;
    ppq_pkg::t_res o_res;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [1:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    // model of the queue contents, head at index 0
    t_slot         slots[$];
    bit            sorted_mode;
    ppq_pkg::t_res pending_res[$];
    t_row          rows[$];
    int            n_errors;
    int            n_sent;

    process_priority_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_cmd  (i_cmd),
        .o_done (o_done),
        .o_res  (o_res),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        n_errors++;
    endtask

    task automatic cmp_field(input string name, input longint got, input longint want);
        if (got != want) begin
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    function automatic ppq_pkg::t_res res_of(input logic [ppq_pkg::PID_W-1:0] p,
                                             input logic [ppq_pkg::PRI_W-1:0] q,
                                             input ppq_pkg::t_status s, input int n);
        ppq_pkg::t_res r;
        r.out_pid      = p;
        r.out_priority = q;
        r.status       = s;
        r.count        = n[ppq_pkg::COUNT_W-1:0];
        r.is_empty     = (n == 0);
        return r;
    endfunction

    // applies one command to the model queue and returns the result it should give
    function automatic ppq_pkg::t_res queue_apply(input ppq_pkg::t_cmd c);
        ppq_pkg::t_res r;
        t_slot         e;
        int            pos;
        int            n;
        r   = '0;
        pos = 0;
        case (c.mode)
            ppq_pkg::OP_INSERT: begin
                if (slots.size() >= DEPTH) begin
                    r.status = ppq_pkg::STS_FULL;
                end else begin
                    pos = slots.size();
                    if (sorted_mode) begin
                        for (int k = 0; k < slots.size(); k++) begin
                            if (slots[k].pri < c.in_priority) begin
                                pos = k;
                                break;
                            end
                        end
                    end
                    e.pid = c.in_pid;
                    e.pri = c.in_priority;
                    slots.insert(pos, e);
                end
            end
            ppq_pkg::OP_REM_HEAD: begin
                if (slots.size() == 0) begin
                    r.status = ppq_pkg::STS_EMPTY;
                end else begin
                    e = slots.pop_front();
                    r.out_pid      = e.pid;
                    r.out_priority = e.pri;
                end
            end
            ppq_pkg::OP_REM_PID: begin
                if (slots.size() == 0) begin
                    r.status = ppq_pkg::STS_EMPTY;
                end else begin
                    pos = -1;
                    for (int k = 0; k < slots.size(); k++) begin
                        if (slots[k].pid == c.in_pid) begin
                            pos = k;
                            break;
                        end
                    end
                    if (pos < 0) begin
                        r.status = ppq_pkg::STS_NOT_FOUND;
                    end else begin
                        r.out_pid      = slots[pos].pid;
                        r.out_priority = slots[pos].pri;
                        slots.delete(pos);
                    end
                end
            end
            default: ;
        endcase
        n          = slots.size();
        r.count    = n[ppq_pkg::COUNT_W-1:0];
        r.is_empty = (n == 0);
        return r;
    endfunction

    // entered and left just after a falling edge
    task automatic send_cmd(input ppq_pkg::t_cmd c, input int idle_pct, input bit has_want,
                            input ppq_pkg::t_res want);
        int            gap;
        ppq_pkg::t_res pred;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, DEPTH + 4) : 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = queue_apply(c);
        pending_res.push_back(has_want ? want : pred);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_res.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_mode(input bit v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ppq_pkg::REG_PMODE;
        pwdata  <= ($urandom() & 32'hffff_fffe) | v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sorted_mode = v;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        cmp_field("priority_mode readback", prdata, v);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void row_cmd(input ppq_pkg::t_op op,
                                    input logic [ppq_pkg::PID_W-1:0] p,
                                    input logic [ppq_pkg::PRI_W-1:0] q, input bit typed,
                                    input ppq_pkg::t_res want);
        t_row r;
        r.kind            = ROW_CMD;
        r.cmd.mode        = op;
        r.cmd.in_pid      = p;
        r.cmd.in_priority = q;
        r.cfg_val         = 1'b0;
        r.has_want        = typed;
        r.want            = want;
        rows.push_back(r);
    endfunction

    function automatic void row_cfg(input bit v);
        t_row r;
        r.kind     = ROW_CFG;
        r.cmd      = '0;
        r.cfg_val  = v;
        r.has_want = 1'b0;
        r.want     = '0;
        rows.push_back(r);
    endfunction

    function automatic logic [ppq_pkg::PRI_W-1:0] pick_priority();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(3) * 85);
            1:       return 8'($urandom_range(120, 123));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [ppq_pkg::PID_W-1:0] pick_pid();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? '1 : '0;
            1, 2, 3: return 31'($urandom_range(1, 15));
            default: return 31'($urandom());
        endcase
    endfunction

    // a run of commands leaning towards filling, draining or neither
    task automatic run_episode(input int n, input int idle_pct);
        int            lean;
        int            roll;
        ppq_pkg::t_cmd c;
        lean = $urandom_range(2);
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            c.in_pid      = pick_pid();
            c.in_priority = pick_priority();
            if (lean == 0) begin
                c.mode = (roll < 75) ? ppq_pkg::OP_INSERT : (roll < 83) ? ppq_pkg::OP_REM_HEAD :
                         (roll < 93) ? ppq_pkg::OP_REM_PID : ppq_pkg::OP_STATUS;
            end else if (lean == 1) begin
                c.mode = (roll < 15) ? ppq_pkg::OP_INSERT : (roll < 60) ? ppq_pkg::OP_REM_HEAD :
                         (roll < 90) ? ppq_pkg::OP_REM_PID : ppq_pkg::OP_STATUS;
            end else begin
                c.mode = (roll < 40) ? ppq_pkg::OP_INSERT : (roll < 60) ? ppq_pkg::OP_REM_HEAD :
                         (roll < 85) ? ppq_pkg::OP_REM_PID : ppq_pkg::OP_STATUS;
            end
            // mostly target a pid that is actually held
            if (c.mode == ppq_pkg::OP_REM_PID && slots.size() != 0 &&
                $urandom_range(9) < 7) begin
                c.in_pid = slots[$urandom_range(slots.size() - 1)].pid;
            end
            send_cmd(c, idle_pct, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        ppq_pkg::t_res want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_res.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
            end else begin
                want = pending_res.pop_front();
                cmp_field("out_pid", o_res.out_pid, want.out_pid);
                cmp_field("out_priority", o_res.out_priority, want.out_priority);
                cmp_field("status", o_res.status, want.status);
                cmp_field("count", o_res.count, want.count);
                cmp_field("is_empty", o_res.is_empty, want.is_empty);
            end
        end
    end

    initial begin
        int idle_pcts[3];
        int target;
        int waited;
        idle_pcts = '{6, 75, 0};
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_cmd     = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        n_errors  = 0;
        n_sent    = 0;
        sorted_mode = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part: arrival order first, then sorted insert and mode swaps
        row_cmd(ppq_pkg::OP_STATUS,   '0,           '0,    1'b1,
                res_of('0, '0, ppq_pkg::STS_OK, 0));
        row_cmd(ppq_pkg::OP_REM_HEAD, '0,           '0,    1'b1,
                res_of('0, '0, ppq_pkg::STS_EMPTY, 0));
        row_cmd(ppq_pkg::OP_REM_PID,  31'd5,        '0,    1'b1,
                res_of('0, '0, ppq_pkg::STS_EMPTY, 0));
        row_cmd(ppq_pkg::OP_INSERT,   '1,           '1,    1'b1,
                res_of('0, '0, ppq_pkg::STS_OK, 1));
        row_cmd(ppq_pkg::OP_INSERT,   '0,           '0,    1'b1,
                res_of('0, '0, ppq_pkg::STS_OK, 2));
        row_cmd(ppq_pkg::OP_INSERT,   31'h2aaaaaaa, 8'h55, 1'b0, '0);
        row_cmd(ppq_pkg::OP_REM_PID,  31'h55555555, 8'haa, 1'b1,
                res_of('0, '0, ppq_pkg::STS_NOT_FOUND, 3));
        row_cmd(ppq_pkg::OP_REM_PID,  '0,           '0,    1'b1,
                res_of('0, '0, ppq_pkg::STS_OK, 2));
        row_cmd(ppq_pkg::OP_REM_HEAD, '0,           '0,    1'b1,
                res_of('1, '1, ppq_pkg::STS_OK, 1));
        row_cfg(1'b1);
        row_cmd(ppq_pkg::OP_INSERT,   31'h55555555, 8'haa, 1'b0, '0);
        row_cmd(ppq_pkg::OP_INSERT,   31'd11,       8'haa, 1'b0, '0);
        row_cmd(ppq_pkg::OP_INSERT,   31'd12,       8'hff, 1'b0, '0);
        row_cmd(ppq_pkg::OP_INSERT,   31'd13,       8'h00, 1'b0, '0);
        row_cmd(ppq_pkg::OP_INSERT,   31'd11,       8'haa, 1'b0, '0);
        row_cmd(ppq_pkg::OP_REM_PID,  31'd11,       '0,    1'b0, '0);
        row_cmd(ppq_pkg::OP_REM_HEAD, '0,           '0,    1'b0, '0);
        // entries already held are not re-sorted by a mode change
        row_cfg(1'b0);
        row_cmd(ppq_pkg::OP_INSERT,   31'd20,       8'hc8, 1'b0, '0);
        row_cfg(1'b1);
        row_cmd(ppq_pkg::OP_INSERT,   31'd21,       8'h64, 1'b0, '0);
        row_cmd(ppq_pkg::OP_STATUS,   '1,           '1,    1'b0, '0);
        row_cmd(ppq_pkg::OP_REM_PID,  31'h2aaaaaaa, '0,    1'b0, '0);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_mode(rows[i].cfg_val);
                @(negedge i_clk);
            end else begin
                send_cmd(rows[i].cmd, 6, rows[i].has_want, rows[i].want);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            target = n_sent + (N_ITEMS - n_sent) / (3 - ph);
            while (n_sent < target) begin
                run_episode($urandom_range(40, 110), idle_pcts[ph]);
                wait_idle();
                write_mode($urandom_range(1));
                @(negedge i_clk);
            end
        end

        start <= 1'b0;
        waited = 0;
        while (pending_res.size() != 0 && waited < 8 * DEPTH) begin
            @(negedge i_clk);
            waited++;
        end
        if (pending_res.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_res.size()));
        end
        repeat (DEPTH + 4) @(negedge i_clk);

        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
